### sv/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types, constants and helper functions of the keypad debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

  localparam int KEY_COUNT = 9;     // keys looked at, 1..9
  localparam int LINES_W   = 9;     // width of the key line sample
  localparam int KEY_W     = 4;     // key number 0..9
  localparam int CODE_W    = 6;     // key code 1..54
  localparam int LIMIT_W   = 8;     // limit registers
  localparam int CNT_W     = 9;     // held sample counter
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [LIMIT_W-1:0] FIRST_HOLD_RST = 8'd66;
  localparam logic [LIMIT_W-1:0] REPEAT_RST     = 8'd20;

  localparam logic [CODE_W-1:0] OFS_HOLD1   = 6'd9;
  localparam logic [CODE_W-1:0] OFS_HOLD2   = 6'd18;
  localparam logic [CODE_W-1:0] OFS_HOLD3   = 6'd27;
  localparam logic [CODE_W-1:0] OFS_REPEAT  = 6'd36;
  localparam logic [CODE_W-1:0] OFS_RELEASE = 6'd45;

  typedef logic [LINES_W-1:0] lines_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_HOLD = 2'd0,
    CFG_REPEAT     = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_HOLD1   = 3'd2,
    PH_HOLD2   = 3'd3,
    PH_HOLD3   = 3'd4,
    PH_REPEAT  = 3'd5
  } phase_t;

  typedef struct packed {
    limit_t first_hold_limit;
    limit_t repeat_limit;
  } cfg_t;

  // Active-low lines; keys outside 1..KEY_COUNT never count as pressed.
  function automatic logic key_pressed(input lines_t lines, input key_t k);
    if (k == '0 || k > KEY_W'(KEY_COUNT)) begin
      return 1'b0;
    end
    return !lines[k - key_t'(1)];
  endfunction

  // Highest-numbered pressed key, zero when none.
  function automatic key_t top_key(input lines_t lines);
    key_t sel;
    sel = '0;
    for (int i = 1; i <= KEY_COUNT; i++) begin
      if (key_pressed(lines, KEY_W'(i))) begin
        sel = KEY_W'(i);
      end
    end
    return sel;
  endfunction

  function automatic code_t stage_offset(input phase_t ph);
    code_t ofs;
    unique case (ph)
      PH_HOLD1:  ofs = OFS_HOLD1;
      PH_HOLD2:  ofs = OFS_HOLD2;
      PH_HOLD3:  ofs = OFS_HOLD3;
      default:   ofs = OFS_REPEAT;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

### sv/kdlp_ifs.sv
// ----------------------------------------------------------------------------
// kdlp channel interfaces
// Sample, key code and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdlp_in_if;
  import kdlp_pkg::*;
  logic   valid;
  logic   ready;
  lines_t key_lines;
  modport source (output valid, output key_lines, input ready);
  modport sink   (input valid, input key_lines, output ready);
endinterface

interface kdlp_out_if;
  import kdlp_pkg::*;
  logic  valid;
  logic  ready;
  code_t key_code;
  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kdlp_cfg_if;
  import kdlp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_DAT_W-1:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

### sv/kdlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdlp_cfg_regs
// Hold-limit register file; writes always accepted, unknown indexes dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  kdlp_cfg_if.sink       cfg_ch,
  output kdlp_pkg::cfg_t cfg
);
  import kdlp_pkg::*;

  limit_t first_hold_r, first_hold_nxt;
  limit_t repeat_r, repeat_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    first_hold_nxt = first_hold_r;
    repeat_nxt     = repeat_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.idx))
        CFG_FIRST_HOLD: first_hold_nxt = cfg_ch.wdata;
        CFG_REPEAT:     repeat_nxt     = cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hold_r <= FIRST_HOLD_RST;
      repeat_r     <= REPEAT_RST;
    end else begin
      first_hold_r <= first_hold_nxt;
      repeat_r     <= repeat_nxt;
    end
  end

  assign cfg.first_hold_limit = first_hold_r;
  assign cfg.repeat_limit     = repeat_r;

endmodule

`default_nettype wire

### sv/kdlp_core.sv
// ----------------------------------------------------------------------------
// kdlp_core
// Debounce / long-press state machine with a registered key code output.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_core (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  kdlp_pkg::cfg_t cfg,
  kdlp_in_if.sink        in_ch,
  kdlp_out_if.source     out_ch
);
  import kdlp_pkg::*;

  phase_t phase_r, phase_nxt;
  key_t   key_r, key_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   rel_r, rel_nxt;
  logic   ovld_r, ovld_nxt;
  code_t  code_r, code_nxt;

  logic   take;
  logic   emit;
  code_t  code;
  logic   down;
  limit_t limit;
  key_t   sel;

  // output register frees up when empty or drained this cycle
  assign in_ch.ready = !ovld_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  assign down  = key_pressed(in_ch.key_lines, key_r);
  assign sel   = top_key(in_ch.key_lines);
  assign limit = (phase_r == PH_HOLD1) ? cfg.first_hold_limit : cfg.repeat_limit;

  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    rel_nxt   = rel_r;
    emit      = 1'b0;
    code      = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (sel != '0) begin
          key_nxt   = sel;
          phase_nxt = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (down) begin
          emit      = 1'b1;
          code      = CODE_W'(key_r);
          phase_nxt = PH_HOLD1;
          cnt_nxt   = '0;
          rel_nxt   = 1'b0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HOLD1, PH_HOLD2, PH_HOLD3, PH_REPEAT: begin
        if (!rel_r && cnt_r > {1'b0, limit}) begin
          // limit passed: stage code, sample itself ignored
          emit    = 1'b1;
          code    = CODE_W'(key_r) + stage_offset(phase_r);
          cnt_nxt = '0;
          unique case (phase_r)
            PH_HOLD1: phase_nxt = PH_HOLD2;
            PH_HOLD2: phase_nxt = PH_HOLD3;
            PH_HOLD3: phase_nxt = PH_REPEAT;
            default:  phase_nxt = PH_REPEAT;
          endcase
        end else if (down) begin
          rel_nxt = 1'b0;
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end else if (!rel_r) begin
          rel_nxt = 1'b1;
        end else begin
          // second released sample in a row
          rel_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          code      = CODE_W'(key_r) + OFS_RELEASE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r && !out_ch.ready;
    code_nxt = code_r;
    if (take && emit) begin
      ovld_nxt = 1'b1;
      code_nxt = code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      key_r   <= '0;
      cnt_r   <= '0;
      rel_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        key_r   <= key_nxt;
        cnt_r   <= cnt_nxt;
        rel_r   <= rel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign out_ch.valid    = ovld_r;
  assign out_ch.key_code = code_r;

endmodule

`default_nettype wire

### sv/keypad_debounce_long_press.sv
// ----------------------------------------------------------------------------
// keypad_debounce_long_press
// Nine-key debouncer with press, long-press repeat and release codes.
// ----------------------------------------------------------------------------
// Takes one sample of nine active-low key lines per beat, one beat per clock
// when the code output is being taken. From idle the highest pressed key is
// picked, confirmed on the next sample and reported as code k (1..9). While
// held, samples are counted: past first_hold_limit the code k+9 is sent,
// then k+18 and k+27 past repeat_limit each, then k+36 every repeat period.
// The beat that carries a stage code is otherwise ignored. Two released
// samples in a row send k+45 and return to idle. Each sample goes through
// a single state update straight into the code output register; the input
// stalls only while a code sits unread in that register. At most one code
// per sample. Register writes (index 0 first_hold_limit, index 1
// repeat_limit) are always accepted; other indexes are dropped. Reset
// values are 66 and 20.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_long_press (
  input wire logic   clk,
  input wire logic   rst_n,
  kdlp_in_if.sink    in_ch,
  kdlp_out_if.source out_ch,
  kdlp_cfg_if.sink   cfg_ch
);
  import kdlp_pkg::*;

  cfg_t cfg;

  // limit registers
  kdlp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // state machine and code register
  kdlp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // sample side only stalls behind an unread code
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without pending code");

  // a new code only follows an accepted sample beat
  a_code_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready))
    else $error("code appeared without a sample beat");

  // every code lies in 1..54
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.key_code >= 6'd1 && out_ch.key_code <= 6'd54))
    else $error("key code out of range");
`endif

endmodule

`default_nettype wire
